FILE: design/rs_pkg.sv
// Shared types and constants for the reservation station and its ALU.
`timescale 1ns / 1ps

package rs_pkg;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WAIT  = 2'd1,
		ST_READY = 2'd2
	} state_t;

	typedef enum logic [1:0] {
		OP_ISSUE = 2'd0,
		OP_BCAST = 2'd1,
		OP_EXEC  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [6:0] opcode;
		logic [2:0] funct3;
		logic       alt;
	} alu_ctrl_t;

	localparam logic [6:0] OPC_ALU    = 7'h33;
	localparam logic [6:0] OPC_BRANCH = 7'h63;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] BR_EQ  = 3'd0;
	localparam logic [2:0] BR_NE  = 3'd1;
	localparam logic [2:0] BR_LT  = 3'd4;
	localparam logic [2:0] BR_GE  = 3'd5;
	localparam logic [2:0] BR_LTU = 3'd6;
	localparam logic [2:0] BR_GEU = 3'd7;

endpackage

FILE: design/rs_req_if.sv
// Request channel: issue, broadcast or execute words into the station.
`timescale 1ns / 1ps

interface rs_req_if #(parameter int TAG_BITS = 5);
	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [6:0]          opcode;
	logic [2:0]          funct3;
	logic                alt_select;
	logic [TAG_BITS-1:0] dest_tag;
	logic [TAG_BITS-1:0] src1_tag;
	logic [31:0]         src1_value;
	logic [TAG_BITS-1:0] src2_tag;
	logic [31:0]         src2_value;
	logic [TAG_BITS-1:0] bus_tag;
	logic [31:0]         bus_value;

	modport source (
		output valid, operation, opcode, funct3, alt_select, dest_tag,
		       src1_tag, src1_value, src2_tag, src2_value, bus_tag, bus_value,
		input  ready
	);
	modport sink (
		input  valid, operation, opcode, funct3, alt_select, dest_tag,
		       src1_tag, src1_value, src2_tag, src2_value, bus_tag, bus_value,
		output ready
	);
endinterface

FILE: design/rs_rsp_if.sv
// Response channel: result bus word and station state after each step.
`timescale 1ns / 1ps

interface rs_rsp_if #(parameter int TAG_BITS = 5);
	logic                valid;
	logic                ready;
	logic                result_valid;
	logic [TAG_BITS-1:0] result_tag;
	logic [31:0]         result_value;
	logic [1:0]          station_state;

	modport source (
		output valid, result_valid, result_tag, result_value, station_state,
		input  ready
	);
	modport sink (
		input  valid, result_valid, result_tag, result_value, station_state,
		output ready
	);
endinterface

FILE: design/rs_alu.sv
// RV32I integer ALU and branch comparator for the station entry.
`timescale 1ns / 1ps

module rs_alu (
	input  rs_pkg::alu_ctrl_t ctrl,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic [31:0]       result
);
	import rs_pkg::*;

	logic [4:0] sh;
	logic       lt_s;
	logic       lt_u;

	always_comb begin
		sh     = b[4:0];
		lt_s   = $signed(a) < $signed(b);
		lt_u   = a < b;
		result = '0;
		if (ctrl.opcode == OPC_BRANCH) begin
			unique case (ctrl.funct3)
				BR_EQ:   result = {31'd0, a == b};
				BR_NE:   result = {31'd0, a != b};
				BR_LT:   result = {31'd0, lt_s};
				BR_GE:   result = {31'd0, !lt_s};
				BR_LTU:  result = {31'd0, lt_u};
				BR_GEU:  result = {31'd0, !lt_u};
				default: result = '0;
			endcase
		end else begin
			unique case (ctrl.funct3)
				F3_ADD:  result = (ctrl.opcode == OPC_ALU && ctrl.alt) ? a - b : a + b;
				F3_SLL:  result = a << sh;
				F3_SLT:  result = {31'd0, lt_s};
				F3_SLTU: result = {31'd0, lt_u};
				F3_XOR:  result = a ^ b;
				F3_SR:   result = ctrl.alt ? $unsigned($signed(a) >>> sh) : a >> sh;
				F3_OR:   result = a | b;
				F3_AND:  result = a & b;
				default: result = '0;
			endcase
		end
	end
endmodule

FILE: design/rs_entry.sv
// Station entry: instruction and operand registers, step logic, ALU.
`timescale 1ns / 1ps

module rs_entry #(
	parameter int TAG_BITS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  rs_pkg::op_t         op,
	input  rs_pkg::alu_ctrl_t   ctrl,
	input  logic [TAG_BITS-1:0] dest_tag,
	input  logic [TAG_BITS-1:0] src1_tag,
	input  logic [31:0]         src1_value,
	input  logic [TAG_BITS-1:0] src2_tag,
	input  logic [31:0]         src2_value,
	input  logic [TAG_BITS-1:0] bus_tag,
	input  logic [31:0]         bus_value,
	output logic                res_valid,
	output logic [TAG_BITS-1:0] res_tag,
	output logic [31:0]         res_value,
	output rs_pkg::state_t      state_next
);
	import rs_pkg::*;

	state_t              state_q;
	alu_ctrl_t           ctrl_q;
	logic [TAG_BITS-1:0] dest_q;
	logic [TAG_BITS-1:0] tag1_q;
	logic [TAG_BITS-1:0] tag2_q;
	logic [31:0]         opnd1_q;
	logic [31:0]         opnd2_q;

	alu_ctrl_t           ctrl_d;
	logic [TAG_BITS-1:0] dest_d;
	logic [TAG_BITS-1:0] tag1_d;
	logic [TAG_BITS-1:0] tag2_d;
	logic [31:0]         opnd1_d;
	logic [31:0]         opnd2_d;
	logic                hit1;
	logic                hit2;
	logic [31:0]         alu_out;

	rs_alu u_alu (
		.ctrl   (ctrl_q),
		.a      (opnd1_q),
		.b      (opnd2_q),
		.result (alu_out)
	);

	always_comb begin
		state_next = state_q;
		ctrl_d     = ctrl_q;
		dest_d     = dest_q;
		tag1_d     = tag1_q;
		tag2_d     = tag2_q;
		opnd1_d    = opnd1_q;
		opnd2_d    = opnd2_q;
		res_valid  = 1'b0;
		res_tag    = '0;
		res_value  = '0;
		hit1       = (tag1_q != '0) && (tag1_q == bus_tag);
		hit2       = (tag2_q != '0) && (tag2_q == bus_tag);
		unique case (op)
			OP_ISSUE: begin
				if (state_q == ST_IDLE) begin
					ctrl_d = ctrl;
					dest_d = dest_tag;
					tag1_d = src1_tag;
					tag2_d = src2_tag;
					if (src1_tag == '0) opnd1_d = src1_value;
					if (src2_tag == '0) opnd2_d = src2_value;
					state_next = (src1_tag == '0 && src2_tag == '0) ? ST_READY : ST_WAIT;
				end
			end
			OP_BCAST: begin
				if (state_q == ST_WAIT) begin
					if (hit1) begin
						opnd1_d = bus_value;
						tag1_d  = '0;
					end
					if (hit2) begin
						opnd2_d = bus_value;
						tag2_d  = '0;
					end
					if (tag1_d == '0 && tag2_d == '0) state_next = ST_READY;
				end
			end
			OP_EXEC: begin
				if (state_q == ST_READY) begin
					res_valid  = 1'b1;
					res_tag    = dest_q;
					res_value  = alu_out;
					state_next = ST_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctrl_q  <= '0;
			dest_q  <= '0;
			tag1_q  <= '0;
			tag2_q  <= '0;
		end else if (step) begin
			state_q <= state_next;
			ctrl_q  <= ctrl_d;
			dest_q  <= dest_d;
			tag1_q  <= tag1_d;
			tag2_q  <= tag2_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			opnd1_q <= opnd1_d;
			opnd2_q <= opnd2_d;
		end
	end

`ifndef SYNTH
	a_ready_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READY |-> (tag1_q == '0 && tag2_q == '0))
		else $error("ready entry still waits on a tag");
	a_wait_has_tag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> (tag1_q != '0 || tag2_q != '0))
		else $error("waiting entry has no pending tag");
	a_exec_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(step && op == OP_EXEC && state_q == ST_READY) |=> state_q == ST_IDLE)
		else $error("execute did not free the entry");
`endif
endmodule

FILE: design/reservation_station_with_alu.sv
// Top level: input register, reservation station entry, output register.
// A word accepted into the input register passes through the entry into the
// output register, whose contents the host sees on rsp. Throughput: one word
// per cycle while rsp is not stalled; the entry state and the output register
// advance together, so each word sees the state left by the one before.
// Reset (arst_n low, asynchronous): entry idle, tags and control cleared,
// both pipeline stages empty; operand values are not cleared.
`timescale 1ns / 1ps

module reservation_station_with_alu #(
	parameter int TAG_BITS = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	rs_req_if.sink    req,
	rs_rsp_if.source  rsp
);
	import rs_pkg::*;

	// Input register: one word waiting for the entry.
	logic                valid_s1;
	op_t                 op_s1;
	alu_ctrl_t           ctrl_s1;
	logic [TAG_BITS-1:0] dest_s1;
	logic [TAG_BITS-1:0] tag1_s1;
	logic [31:0]         val1_s1;
	logic [TAG_BITS-1:0] tag2_s1;
	logic [31:0]         val2_s1;
	logic [TAG_BITS-1:0] btag_s1;
	logic [31:0]         bval_s1;

	// Output register: the response word for the host.
	logic                valid_s2;
	logic                rvalid_s2;
	logic [TAG_BITS-1:0] rtag_s2;
	logic [31:0]         rvalue_s2;
	state_t              rstate_s2;

	logic                out_adv;
	logic                step;
	logic                accept;
	logic                res_valid;
	logic [TAG_BITS-1:0] res_tag;
	logic [31:0]         res_value;
	state_t              state_next;

	// The output stage moves whenever it is empty or being drained; the
	// input stage can then hand its word over and take a new one the same cycle.
	assign out_adv   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && out_adv;
	assign req.ready = !valid_s1 || out_adv;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload; hold it while the output is stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(req.operation);
			ctrl_s1 <= '{opcode: req.opcode, funct3: req.funct3, alt: req.alt_select};
			dest_s1 <= req.dest_tag;
			tag1_s1 <= req.src1_tag;
			val1_s1 <= req.src1_value;
			tag2_s1 <= req.src2_tag;
			val2_s1 <= req.src2_value;
			btag_s1 <= req.bus_tag;
			bval_s1 <= req.bus_value;
		end
	end

	// Entry: updates its state on step and computes the response.
	rs_entry #(.TAG_BITS(TAG_BITS)) u_entry (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.op         (op_s1),
		.ctrl       (ctrl_s1),
		.dest_tag   (dest_s1),
		.src1_tag   (tag1_s1),
		.src1_value (val1_s1),
		.src2_tag   (tag2_s1),
		.src2_value (val2_s1),
		.bus_tag    (btag_s1),
		.bus_value  (bval_s1),
		.res_valid  (res_valid),
		.res_tag    (res_tag),
		.res_value  (res_value),
		.state_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// Advance the response word; drop nothing while the host stalls.
	always_ff @(posedge clk) begin
		if (step) begin
			rvalid_s2 <= res_valid;
			rtag_s2   <= res_tag;
			rvalue_s2 <= res_value;
			rstate_s2 <= state_next;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.result_valid  = rvalid_s2;
	assign rsp.result_tag    = rtag_s2;
	assign rsp.result_value  = rvalue_s2;
	assign rsp.station_state = rstate_s2;

`ifndef SYNTH
	a_exec_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rvalid_s2) |-> rstate_s2 == ST_IDLE)
		else $error("executed word does not report an idle entry");
	a_no_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rvalid_s2) |-> (rtag_s2 == '0 && rvalue_s2 == '0))
		else $error("word without result carries a tag or value");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_adv) |=> (valid_s1 && $stable(op_s1) && $stable(bval_s1)))
		else $error("input register lost a stalled word");
`endif
endmodule
